// ----- rtl/rgbconv_pkg.sv -----
// Shared constants and payload types of the RGB 3x3 convolution unit.
`default_nettype none
package rgbconv_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WEFF_W    = COL_W + 1;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd5;

    localparam logic [59:0] COEF_LOW_RESET  = 60'd4503599627370496;
    localparam logic [10:0] WIDTH_RESET     = 11'd640;
    localparam logic [15:0] HEIGHT_RESET    = 16'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_in_run;
        logic       frame_done;
    } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/rgb_kernel_convolution_3x3_unit.sv -----
// RGB 3x3 convolution with replicated borders, line stores and iterative divide.
//
// Pixels enter in raster order, one request at a time; results of a row come
// out one row late, and frame_width flush requests after the frame emit the
// last row. A request that yields no result ends after its line store update;
// each result runs through tap accumulation (three 12x9 lane multipliers, one
// tap per cycle), division setup, bit-serial division, rounding and output,
// and the output step waits on m_ready while the output register is full. The
// two line stores are single-port synchronous memories read when a request
// is taken and written back in the cycle after. The output register holds a
// result while the next request is taken. Geometry writes restart the frame.
`default_nettype none
module rgb_kernel_convolution_3x3_unit
    import rgbconv_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_payload,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_payload
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_PREP  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam int ACC_W = 26;
    localparam int Q_W   = 24;

    // configuration
    logic [59:0] coef_low_reg;
    logic [47:0] coef_high_reg;
    logic        flip_reg;
    logic        normalize_reg;
    logic [10:0] fwidth_reg;
    logic [15:0] fheight_reg;

    // frame state
    logic [COL_W-1:0] column_count_reg;
    logic [15:0]      row_count_reg;
    logic             flushing_reg;
    logic [2:0]       state_reg;

    logic [23:0] window_reg [3][3];
    logic [23:0] mem_mid [MAX_WIDTH];
    logic [23:0] mem_top [MAX_WIDTH];
    logic [23:0] mid_q_reg;
    logic [23:0] top_q_reg;

    logic [COL_W-1:0] col_reg;
    logic [23:0]      fresh_reg;

    // result bookkeeping
    logic       second_pend_reg;
    logic [1:0] second_lf_reg;
    logic [1:0] cur_lf_reg;
    logic [1:0] cur_cn_reg;
    logic       fdone_reg;

    logic [1:0] kr_reg;
    logic [1:0] kc_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [15:0]      csum_reg;

    logic [14:0]    dmag_reg;
    logic [Q_W-1:0] quo_reg [3];
    logic [14:0]    rem_reg [3];
    logic [2:0]     force_reg;
    logic [7:0]     force_val_reg [3];
    logic [4:0]     iter_reg;
    logic [7:0]     res_reg [3];

    out_item_t m_payload_reg;
    logic      m_valid_reg;

    // effective geometry
    logic [31:0]       fw32;
    logic [WEFF_W-1:0] w_eff;
    logic [15:0]       h_eff;
    logic [WEFF_W-1:0] col_clamp_w;
    logic [COL_W-1:0]  col_clamp;

    always_comb begin
        fw32 = 32'(fwidth_reg);
        if (fw32 == 32'd0) begin
            w_eff = WEFF_W'(1);
        end else if (fw32 > 32'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(fw32);
        end
        h_eff = (fheight_reg == 16'd0) ? 16'd1 : fheight_reg;
        col_clamp_w = ({1'b0, column_count_reg} >= w_eff) ? (w_eff - WEFF_W'(1))
                                                         : {1'b0, column_count_reg};
        col_clamp = col_clamp_w[COL_W-1:0];
    end

    logic accept;
    logic take;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign take    = accept && (s_payload.operation == flushing_reg);

    // line store read when a request whose operation matches the frame phase is taken
    always_ff @(posedge aclk) begin
        if (take) begin
            mid_q_reg <= mem_mid[col_clamp];
            top_q_reg <= mem_top[col_clamp];
        end
        if (state_reg == ST_UPD) begin
            mem_mid[col_reg] <= fresh_reg;
            mem_top[col_reg] <= mid_q_reg;
        end
    end

    // update stage values
    logic [23:0]       upd_top;
    logic [23:0]       upd_bot;
    logic              upd_last;
    logic              upd_e1;
    logic              upd_e2;
    logic [WEFF_W-1:0] col_inc;
    logic [16:0]       row_inc;

    always_comb begin
        upd_top  = (row_count_reg == 16'd1) ? mid_q_reg : top_q_reg;
        upd_bot  = flushing_reg ? mid_q_reg : fresh_reg;
        upd_last = ({1'b0, col_reg} == (w_eff - WEFF_W'(1)));
        upd_e1   = (row_count_reg != 16'd0) && (col_reg != '0);
        upd_e2   = (row_count_reg != 16'd0) && upd_last;
        col_inc  = {1'b0, col_reg} + WEFF_W'(1);
        row_inc  = {1'b0, row_count_reg} + 17'd1;
    end

    // tap selection
    logic [3:0]         tap_idx;
    logic [3:0]         coef_idx;
    logic signed [11:0] coef;
    logic [1:0]         col_sel;
    logic [23:0]        tap_px;
    logic               tap_last;

    always_comb begin
        tap_idx  = 4'({kr_reg, 1'b0}) + 4'(kr_reg) + 4'(kc_reg);
        coef_idx = flip_reg ? (4'd8 - tap_idx) : tap_idx;
        if (coef_idx < 4'd5) begin
            coef = coef_low_reg[coef_idx*12 +: 12];
        end else begin
            coef = coef_high_reg[(coef_idx - 4'd5)*12 +: 12];
        end
        case (kc_reg)
            2'd0:    col_sel = cur_lf_reg;
            2'd1:    col_sel = cur_cn_reg;
            default: col_sel = 2'd2;
        endcase
        tap_px   = window_reg[kr_reg][col_sel];
        tap_last = (kr_reg == 2'd2) && (kc_reg == 2'd2);
    end

    // division setup, step and rounding per lane
    logic signed [15:0]      div_d;
    logic                    div_dneg;
    logic signed [ACC_W-1:0] s_adj [3];
    logic [15:0]             div_shift [3];
    logic [15:0]             twice_rem [3];
    logic [Q_W:0]            q_round [3];
    logic                    round_up [3];

    always_comb begin
        div_d    = normalize_reg ? csum_reg : 16'sd16;
        div_dneg = div_d[15];
        for (int l = 0; l < 3; l++) begin
            s_adj[l]     = div_dneg ? -acc_reg[l] : acc_reg[l];
            div_shift[l] = {rem_reg[l], quo_reg[l][Q_W-1]};
            twice_rem[l] = {rem_reg[l], 1'b0};
            round_up[l]  = (twice_rem[l] > {1'b0, dmag_reg})
                        || ((twice_rem[l] == {1'b0, dmag_reg}) && quo_reg[l][0]);
            q_round[l]   = {1'b0, quo_reg[l]} + (Q_W+1)'(round_up[l]);
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_low_reg     <= COEF_LOW_RESET;
            coef_high_reg    <= '0;
            flip_reg         <= 1'b0;
            normalize_reg    <= 1'b0;
            fwidth_reg       <= WIDTH_RESET;
            fheight_reg      <= HEIGHT_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            flushing_reg     <= 1'b0;
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            second_pend_reg  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    window_reg[i][j] <= '0;
                end
            end
        end else begin
            // drop the sent result unless a new one is loaded below
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        col_reg   <= col_clamp;
                        fresh_reg <= flushing_reg ? 24'd0
                            : {s_payload.red_in, s_payload.green_in, s_payload.blue_in};
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    for (int i = 0; i < 3; i++) begin
                        window_reg[i][0] <= window_reg[i][1];
                        window_reg[i][1] <= window_reg[i][2];
                    end
                    window_reg[0][2] <= upd_top;
                    window_reg[1][2] <= mid_q_reg;
                    window_reg[2][2] <= upd_bot;
                    fdone_reg       <= flushing_reg && upd_last;
                    second_pend_reg <= upd_e1 && upd_e2;
                    second_lf_reg   <= (col_reg != '0) ? 2'd1 : 2'd2;
                    if (upd_e1) begin
                        cur_lf_reg <= (col_reg == COL_W'(1)) ? 2'd1 : 2'd0;
                        cur_cn_reg <= 2'd1;
                    end else begin
                        cur_lf_reg <= (col_reg != '0) ? 2'd1 : 2'd2;
                        cur_cn_reg <= 2'd2;
                    end
                    kr_reg   <= 2'd0;
                    kc_reg   <= 2'd0;
                    csum_reg <= '0;
                    for (int l = 0; l < 3; l++) begin
                        acc_reg[l] <= '0;
                    end
                    state_reg <= (upd_e1 || upd_e2) ? ST_MAC : ST_IDLE;
                    // advance counters
                    if (col_inc >= w_eff) begin
                        column_count_reg <= '0;
                        if (flushing_reg) begin
                            flushing_reg  <= 1'b0;
                            row_count_reg <= '0;
                        end else begin
                            row_count_reg <= row_inc[15:0];
                            if (row_inc >= {1'b0, h_eff}) begin
                                flushing_reg <= 1'b1;
                            end
                        end
                    end else begin
                        column_count_reg <= col_inc[COL_W-1:0];
                    end
                end
                ST_MAC: begin
                    csum_reg <= csum_reg + 16'(coef);
                    for (int l = 0; l < 3; l++) begin
                        acc_reg[l] <= acc_reg[l]
                            + ACC_W'(coef * $signed({1'b0, tap_px[16-8*l +: 8]}));
                    end
                    if (kc_reg == 2'd2) begin
                        kc_reg <= 2'd0;
                        kr_reg <= kr_reg + 2'd1;
                    end else begin
                        kc_reg <= kc_reg + 2'd1;
                    end
                    if (tap_last) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    dmag_reg <= div_dneg ? 15'(-div_d) : div_d[14:0];
                    for (int l = 0; l < 3; l++) begin
                        quo_reg[l] <= s_adj[l][Q_W-1:0];
                        rem_reg[l] <= '0;
                        if (div_d == 16'sd0) begin
                            force_reg[l]     <= 1'b1;
                            force_val_reg[l] <= (acc_reg[l] > 0) ? 8'd255 : 8'd0;
                        end else begin
                            force_reg[l]     <= (s_adj[l] <= 0);
                            force_val_reg[l] <= 8'd0;
                        end
                    end
                    iter_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    for (int l = 0; l < 3; l++) begin
                        if (div_shift[l] >= {1'b0, dmag_reg}) begin
                            rem_reg[l] <= 15'(div_shift[l] - {1'b0, dmag_reg});
                            quo_reg[l] <= {quo_reg[l][Q_W-2:0], 1'b1};
                        end else begin
                            rem_reg[l] <= div_shift[l][14:0];
                            quo_reg[l] <= {quo_reg[l][Q_W-2:0], 1'b0};
                        end
                    end
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == 5'(Q_W - 1)) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    for (int l = 0; l < 3; l++) begin
                        if (force_reg[l]) begin
                            res_reg[l] <= force_val_reg[l];
                        end else if (q_round[l] > (Q_W+1)'(255)) begin
                            res_reg[l] <= 8'd255;
                        end else begin
                            res_reg[l] <= q_round[l][7:0];
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg             <= 1'b1;
                        m_payload_reg.red_out   <= res_reg[0];
                        m_payload_reg.green_out <= res_reg[1];
                        m_payload_reg.blue_out  <= res_reg[2];
                        m_payload_reg.last_in_run <= !second_pend_reg;
                        m_payload_reg.frame_done  <= !second_pend_reg && fdone_reg;
                        if (second_pend_reg) begin
                            second_pend_reg <= 1'b0;
                            cur_lf_reg      <= second_lf_reg;
                            cur_cn_reg      <= 2'd2;
                            kr_reg          <= 2'd0;
                            kc_reg          <= 2'd0;
                            csum_reg        <= '0;
                            for (int l = 0; l < 3; l++) begin
                                acc_reg[l] <= '0;
                            end
                            state_reg <= ST_MAC;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // configuration writes must arrive only while idle; the block does not enforce it
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_COEF_LOW:  coef_low_reg  <= cfg_wr_data[59:0];
                    CFG_COEF_HIGH: coef_high_reg <= cfg_wr_data[47:0];
                    CFG_FLIP:      flip_reg      <= cfg_wr_data[0];
                    CFG_NORMALIZE: normalize_reg <= cfg_wr_data[0];
                    CFG_WIDTH, CFG_HEIGHT: begin
                        if (cfg_index == CFG_WIDTH) begin
                            fwidth_reg <= cfg_wr_data[10:0];
                        end else begin
                            fheight_reg <= cfg_wr_data[15:0];
                        end
                        column_count_reg <= '0;
                        row_count_reg    <= '0;
                        flushing_reg     <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
`default_nettype wire
